// ----- rtl/ecap_pkg.sv -----
`default_nettype none

package ecap_pkg;

  localparam int FIELD_WIDTH = 61;
  localparam int SCALAR_WIDTH = 63;
  localparam int CFG_INDEX_WIDTH = 2;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MODULUS = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CURVE_A = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CURVE_B = 2'd2;

  localparam logic [63:0] MODULUS_RESET = 64'd1157920892373161953;
  localparam logic [63:0] CURVE_A_RESET = 64'd3;

endpackage

`default_nettype wire

// ----- rtl/ecap_mulmod.sv -----
`default_nettype none

module ecap_mulmod #(
  parameter int FIELD_WIDTH = 61
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [FIELD_WIDTH-1:0] op_a,
  input  wire logic [FIELD_WIDTH-1:0] op_b,
  input  wire logic [FIELD_WIDTH-1:0] modulus,
  output logic                        done,
  output logic [FIELD_WIDTH-1:0]      result
);

  localparam int W = FIELD_WIDTH;
  localparam int CW = $clog2(W + 1);
  localparam logic [CW-1:0] CNT_INIT = CW'(W);
  localparam logic [CW-1:0] CNT_ONE = CW'(1);

  logic [W-1:0]  a_q;
  logic [W-1:0]  b_q;
  logic [W-1:0]  m_q;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [W:0]    dbl;
  logic [W:0]    dbl_r;
  logic [W:0]    sum;
  logic [W:0]    sum_r;

  // One bit of the multiplier per cycle, MSB first: double, then add.
  always_comb begin
    dbl = {result, 1'b0};
    dbl_r = (dbl >= {1'b0, m_q}) ? dbl - {1'b0, m_q} : dbl;
    sum = {1'b0, dbl_r[W-1:0]} + (b_q[W-1] ? {1'b0, a_q} : {(W+1){1'b0}});
    sum_r = (sum >= {1'b0, m_q}) ? sum - {1'b0, m_q} : sum;
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      a_q <= op_a;
      b_q <= op_b;
      m_q <= modulus;
      result <= '0;
      cnt <= CNT_INIT;
      busy <= 1'b1;
    end else if (busy) begin
      result <= sum_r[W-1:0];
      b_q <= {b_q[W-2:0], 1'b0};
      cnt <= cnt - CNT_ONE;
      if (cnt == CNT_ONE) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ec_affine_point_unit_core.sv -----
// Affine point unit for a short Weierstrass curve over a prime field.
// Configuration: cfg_wr_en, cfg_index and cfg_data write the modulus (index 0)
// and the coefficient a (index 1); other indexes are ignored. The user must write
// them only while the unit is idle; the block itself does not enforce this.
// Input channel: in_valid with in_stall; a transfer happens when in_valid is high
// and in_stall is low. func selects point addition or scalar multiplication.
// Output channel: out_valid with out_stall carries r_x, r_y and r_inf.
// All field products, reductions and inversions run on one bit-serial modular
// multiplier; additions and subtractions are combinational. An inversion is a
// square-and-multiply over the bits of the modulus minus two, at most about
// 2 * FIELD_WIDTH products. One point operation therefore costs about
// (2 * FIELD_WIDTH + 6) products, and an addition item takes that plus five
// reductions of the operands. A scalar multiplication performs up to two point
// operations per scalar bit up to the highest set bit.
// Items are processed one at a time. A finished result waits in the output
// register while out_stall is high; the next item may already be accepted then.
// Synchronous reset rst returns to idle, drops out_valid and restores the
// register reset values.
`default_nettype none

module ec_affine_point_unit_core #(
  parameter int FIELD_WIDTH = ecap_pkg::FIELD_WIDTH
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [ecap_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [FIELD_WIDTH-1:0]               cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic                                 func,
  input  wire logic [FIELD_WIDTH-1:0]               p_x,
  input  wire logic [FIELD_WIDTH-1:0]               p_y,
  input  wire logic                                 p_inf,
  input  wire logic [FIELD_WIDTH-1:0]               q_x,
  input  wire logic [FIELD_WIDTH-1:0]               q_y,
  input  wire logic                                 q_inf,
  input  wire logic [ecap_pkg::SCALAR_WIDTH-1:0]    scalar,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [FIELD_WIDTH-1:0]                    r_x,
  output logic [FIELD_WIDTH-1:0]                    r_y,
  output logic                                      r_inf
);

  import ecap_pkg::*;

  localparam int W = FIELD_WIDTH;
  localparam logic [W-1:0] ZERO = '0;
  localparam logic [W-1:0] ONE = W'(1);
  localparam logic [W-1:0] TWO = W'(2);
  localparam logic [W-1:0] THREE = W'(3);

  typedef enum logic [4:0] {
    S_IDLE, S_RED_A, S_RED_PX, S_RED_PY, S_RED_QX, S_RED_QY, S_SETUP,
    S_MUL_LOOP, S_ADD_START, S_DBL_SQ, S_DBL_MUL3, S_DBL_DEN, S_INV_INIT,
    S_INV_MUL, S_INV_SQ, S_LAM, S_X_SQ, S_Y_MUL, S_ADD_DONE, S_FIN
  } state_t;

  function automatic logic [W-1:0] fadd(logic [W-1:0] a, logic [W-1:0] b,
                                        logic [W-1:0] m);
    logic [W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] fsub(logic [W-1:0] a, logic [W-1:0] b,
                                        logic [W-1:0] m);
    return (a >= b) ? a - b : a + (m - b);
  endfunction

  state_t state;
  logic [W-1:0] modulus_reg;
  logic [W-1:0] curve_a_reg;
  logic [W-1:0] m;
  logic [W-1:0] ca;
  logic         func_q;
  logic [SCALAR_WIDTH-1:0] k;
  logic         phase;
  logic [W-1:0] px, py, qx, qy, accx, accy, ux, uy, vx, vy, wx, wy;
  logic         pinf, qinf, accinf, uinf, vinf, winf;
  logic [W-1:0] num, den, inv_r, base, e, t, lam;
  logic         pending;
  logic         mul_start;
  logic [W-1:0] mul_a, mul_b;
  logic         mul_done;
  logic [W-1:0] mul_res;

  assign in_stall = rst || (state != S_IDLE);

  ecap_mulmod #(.FIELD_WIDTH(W)) u_mulmod (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .op_a    (mul_a),
    .op_b    (mul_b),
    .modulus (m),
    .done    (mul_done),
    .result  (mul_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus_reg <= MODULUS_RESET[W-1:0];
      curve_a_reg <= CURVE_A_RESET[W-1:0];
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_MODULUS: modulus_reg <= cfg_data;
        REG_CURVE_A: curve_a_reg <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    mul_start <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      pending <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_FIN) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            m <= (modulus_reg < THREE) ? THREE : modulus_reg;
            ca <= curve_a_reg;
            func_q <= func;
            k <= scalar;
            phase <= 1'b0;
            px <= p_x;
            py <= p_y;
            pinf <= p_inf;
            qx <= q_x;
            qy <= q_y;
            qinf <= q_inf;
            state <= S_RED_A;
          end
        end
        S_RED_A: begin
          if (!pending) begin
            mul_start <= 1'b1; mul_a <= ONE; mul_b <= ca; pending <= 1'b1;
          end else if (mul_done) begin
            pending <= 1'b0; ca <= mul_res; state <= S_RED_PX;
          end
        end
        S_RED_PX: begin
          if (!pending) begin
            mul_start <= 1'b1; mul_a <= ONE; mul_b <= px; pending <= 1'b1;
          end else if (mul_done) begin
            pending <= 1'b0; px <= mul_res; state <= S_RED_PY;
          end
        end
        S_RED_PY: begin
          if (!pending) begin
            mul_start <= 1'b1; mul_a <= ONE; mul_b <= py; pending <= 1'b1;
          end else if (mul_done) begin
            pending <= 1'b0; py <= mul_res; state <= S_RED_QX;
          end
        end
        S_RED_QX: begin
          if (!pending) begin
            mul_start <= 1'b1; mul_a <= ONE; mul_b <= qx; pending <= 1'b1;
          end else if (mul_done) begin
            pending <= 1'b0; qx <= mul_res; state <= S_RED_QY;
          end
        end
        S_RED_QY: begin
          if (!pending) begin
            mul_start <= 1'b1; mul_a <= ONE; mul_b <= qy; pending <= 1'b1;
          end else if (mul_done) begin
            pending <= 1'b0; qy <= mul_res; state <= S_SETUP;
          end
        end
        S_SETUP: begin
          if (pinf) begin
            px <= ZERO; py <= ZERO;
          end
          if (qinf) begin
            qx <= ZERO; qy <= ZERO;
          end
          ux <= pinf ? ZERO : px;
          uy <= pinf ? ZERO : py;
          uinf <= pinf;
          vx <= qinf ? ZERO : qx;
          vy <= qinf ? ZERO : qy;
          vinf <= qinf;
          accx <= ZERO;
          accy <= ZERO;
          accinf <= 1'b1;
          state <= func_q ? S_MUL_LOOP : S_ADD_START;
        end
        S_MUL_LOOP: begin
          if (k == '0) begin
            wx <= accx; wy <= accy; winf <= accinf;
            state <= S_FIN;
          end else if (!phase) begin
            if (k[0]) begin
              ux <= accx; uy <= accy; uinf <= accinf;
              vx <= px; vy <= py; vinf <= pinf;
              state <= S_ADD_START;
            end else begin
              phase <= 1'b1;
            end
          end else begin
            ux <= px; uy <= py; uinf <= pinf;
            vx <= px; vy <= py; vinf <= pinf;
            state <= S_ADD_START;
          end
        end
        S_ADD_START: begin
          if (uinf) begin
            wx <= vx; wy <= vy; winf <= vinf; state <= S_ADD_DONE;
          end else if (vinf) begin
            wx <= ux; wy <= uy; winf <= 1'b0; state <= S_ADD_DONE;
          end else if (ux == vx && uy == fsub(ZERO, vy, m)) begin
            wx <= ZERO; wy <= ZERO; winf <= 1'b1; state <= S_ADD_DONE;
          end else if (ux == vx && uy == vy) begin
            state <= S_DBL_SQ;
          end else begin
            num <= fsub(vy, uy, m);
            den <= fsub(vx, ux, m);
            state <= S_INV_INIT;
          end
        end
        S_DBL_SQ: begin
          if (!pending) begin
            mul_start <= 1'b1; mul_a <= ux; mul_b <= ux; pending <= 1'b1;
          end else if (mul_done) begin
            pending <= 1'b0; t <= mul_res; state <= S_DBL_MUL3;
          end
        end
        S_DBL_MUL3: begin
          if (!pending) begin
            mul_start <= 1'b1; mul_a <= (m == THREE) ? ZERO : THREE; mul_b <= t;
            pending <= 1'b1;
          end else if (mul_done) begin
            pending <= 1'b0; t <= mul_res; state <= S_DBL_DEN;
          end
        end
        S_DBL_DEN: begin
          if (!pending) begin
            num <= fadd(t, ca, m);
            mul_start <= 1'b1; mul_a <= TWO; mul_b <= uy; pending <= 1'b1;
          end else if (mul_done) begin
            pending <= 1'b0; den <= mul_res; state <= S_INV_INIT;
          end
        end
        S_INV_INIT: begin
          e <= m - TWO;
          inv_r <= ONE;
          base <= den;
          state <= S_INV_MUL;
        end
        S_INV_MUL: begin
          if (!pending) begin
            if (e[0]) begin
              mul_start <= 1'b1; mul_a <= inv_r; mul_b <= base; pending <= 1'b1;
            end else begin
              state <= S_INV_SQ;
            end
          end else if (mul_done) begin
            pending <= 1'b0; inv_r <= mul_res; state <= S_INV_SQ;
          end
        end
        S_INV_SQ: begin
          if (!pending) begin
            mul_start <= 1'b1; mul_a <= base; mul_b <= base; pending <= 1'b1;
          end else if (mul_done) begin
            pending <= 1'b0;
            base <= mul_res;
            e <= {1'b0, e[W-1:1]};
            state <= (e[W-1:1] == '0) ? S_LAM : S_INV_MUL;
          end
        end
        S_LAM: begin
          if (!pending) begin
            mul_start <= 1'b1; mul_a <= num; mul_b <= inv_r; pending <= 1'b1;
          end else if (mul_done) begin
            pending <= 1'b0; lam <= mul_res; state <= S_X_SQ;
          end
        end
        S_X_SQ: begin
          if (!pending) begin
            t <= fadd(ux, vx, m);
            mul_start <= 1'b1; mul_a <= lam; mul_b <= lam; pending <= 1'b1;
          end else if (mul_done) begin
            pending <= 1'b0; wx <= fsub(mul_res, t, m); state <= S_Y_MUL;
          end
        end
        S_Y_MUL: begin
          if (!pending) begin
            mul_start <= 1'b1; mul_a <= lam; mul_b <= fsub(ux, wx, m);
            pending <= 1'b1;
          end else if (mul_done) begin
            pending <= 1'b0; wy <= fsub(mul_res, uy, m); winf <= 1'b0;
            state <= S_ADD_DONE;
          end
        end
        S_ADD_DONE: begin
          if (!func_q) begin
            state <= S_FIN;
          end else if (!phase) begin
            accx <= wx; accy <= wy; accinf <= winf;
            phase <= 1'b1;
            state <= S_MUL_LOOP;
          end else begin
            px <= wx; py <= wy; pinf <= winf;
            phase <= 1'b0;
            k <= {1'b0, k[SCALAR_WIDTH-1:1]};
            state <= S_MUL_LOOP;
          end
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            r_x <= winf ? ZERO : wx;
            r_y <= winf ? ZERO : wy;
            r_inf <= winf;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
